### rtl/core/numeric_char_ref_to_utf8_macros.svh
// Assertion macros used by the checker of the reference decoder.
`ifndef NUMERIC_CHAR_REF_TO_UTF8_MACROS_SVH
`define NUMERIC_CHAR_REF_TO_UTF8_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NCHR_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nchr: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define NCHR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nchr: next-cycle check failed");

`endif

### rtl/core/nchr_pkg.sv
`timescale 1ns / 1ps

package nchr_pkg;

  // Default number of held bytes of a candidate reference.
  localparam int PENDING_DEPTH_DEF = 32;

  // Source of the byte loaded into the output register.
  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_FLUSH,
    SEL_TAIL,
    SEL_MARK
  } sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       load;
    sel_t       sel;
    logic       last;
    logic       text_end;
    logic       rd_en;
    logic [1:0] tail_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       out_free;
    logic       p_has_flush;
    logic [2:0] p_tail_n;
    logic       p_marker;
    logic       p_fin;
    logic [2:0] q_tail_n;
    logic       q_marker;
    logic       q_fin;
  } sts_t;

endpackage

### rtl/core/nchr_in_if.sv
`timescale 1ns / 1ps

interface nchr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

### rtl/core/nchr_out_if.sv
`timescale 1ns / 1ps

interface nchr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output byte_present,
                  output run_last, output text_end, input ready);
  modport sink (input valid, input out_byte, input byte_present,
                input run_last, input text_end, output ready);
endinterface

### rtl/core/nchr_datapath.sv
`timescale 1ns / 1ps

module nchr_datapath
  import nchr_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [7:0]                           in_byte,
  input  logic                                 final_byte,
  input  cmd_t                                 cmd,
  input  logic [$clog2(PENDING_DEPTH)-1:0]     rd_addr,
  output sts_t                                 sts,
  output logic [$clog2(PENDING_DEPTH+1)-1:0]   flush_cnt,
  nchr_out_if.source                           dout
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = $clog2(PENDING_DEPTH);

  localparam logic [7:0]  CH_AMP   = 8'h26;
  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_SEMI  = 8'h3B;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [20:0] CP_MAX   = 21'h10FFFF;

  typedef enum logic [3:0] {
    PH_IDLE, PH_AMP, PH_HASH, PH_START, PH_SPACE,
    PH_SIGN, PH_ZERO, PH_PREFIX, PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {ACT_BUF, ACT_DONE, ACT_FAIL} act_t;

  // Parse state of the candidate reference.
  phase_t          phase;
  logic            hex_mode;
  logic            minus_seen;
  logic [20:0]     value_acc;
  logic            value_overflow;
  logic [CW-1:0]   pending_count;
  logic [7:0]      pending_mem [PENDING_DEPTH];
  logic [7:0]      rd_data;

  // Plan of the accepted word, held while its results drain.
  logic [CW-1:0]   flush_q;
  logic [2:0]      tail_n_q;
  logic [7:0]      tail_q [4];
  logic            fin_q;
  logic            marker_q;

  // Combinational decode of the incoming byte.
  act_t            act;
  phase_t          nx;
  logic            set_hex;
  logic            dig_v;
  logic [3:0]      dig_val;
  logic            is_x;
  logic            is_ws;
  logic [25:0]     mul;
  logic [25:0]     acc_sum;
  logic            drop;
  logic [CW-1:0]   plan_flush;
  logic [2:0]      plan_tail_n;
  logic [7:0]      tail_c [4];
  logic [2:0]      utf_n;
  logic [7:0]      utf_b [4];
  logic            out_free;

  // Character classes and digit value in the current base.
  always_comb begin
    is_x  = (in_byte == 8'h78) || (in_byte == 8'h58);
    is_ws = (in_byte == 8'h20) || ((in_byte >= 8'h09) && (in_byte <= 8'h0D));
    dig_v   = 1'b0;
    dig_val = 4'd0;
    if ((in_byte >= 8'h30) && (in_byte <= 8'h39)) begin
      dig_v   = 1'b1;
      dig_val = 4'(in_byte - 8'h30);
    end else if (hex_mode && (in_byte >= 8'h61) && (in_byte <= 8'h66)) begin
      dig_v   = 1'b1;
      dig_val = 4'(in_byte - 8'h57);
    end else if (hex_mode && (in_byte >= 8'h41) && (in_byte <= 8'h46)) begin
      dig_v   = 1'b1;
      dig_val = 4'(in_byte - 8'h37);
    end
  end

  // Next parse phase for a byte inside a reference; idle counts as a failure
  // with nothing held, which lets the idle case share the failure path.
  always_comb begin
    phase_t eff;
    act     = ACT_FAIL;
    nx      = PH_IDLE;
    set_hex = 1'b0;
    eff     = phase;
    case (phase)
      PH_AMP: begin
        if (in_byte == CH_HASH) begin
          act = ACT_BUF;
          nx  = PH_HASH;
        end
      end
      PH_HASH, PH_START, PH_SPACE, PH_SIGN: begin
        if ((phase == PH_HASH) && is_x) begin
          act     = ACT_BUF;
          nx      = PH_START;
          set_hex = 1'b1;
        end else begin
          if (phase == PH_HASH) eff = PH_START;
          if ((eff == PH_START) && (in_byte == CH_SEMI)) begin
            act = ACT_DONE;
          end else if ((eff != PH_SIGN) && is_ws) begin
            act = ACT_BUF;
            nx  = PH_SPACE;
          end else if ((eff != PH_SIGN) &&
                       ((in_byte == CH_PLUS) || (in_byte == CH_MINUS))) begin
            act = ACT_BUF;
            nx  = PH_SIGN;
          end else if (hex_mode && (in_byte == CH_ZERO)) begin
            act = ACT_BUF;
            nx  = PH_ZERO;
          end else if (dig_v) begin
            act = ACT_BUF;
            nx  = PH_DIGITS;
          end
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          act = ACT_BUF;
          nx  = PH_PREFIX;
        end else if (dig_v) begin
          act = ACT_BUF;
          nx  = PH_DIGITS;
        end else if (in_byte == CH_SEMI) begin
          act = ACT_DONE;
        end
      end
      PH_PREFIX: begin
        if (dig_v) begin
          act = ACT_BUF;
          nx  = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (dig_v) begin
          act = ACT_BUF;
          nx  = PH_DIGITS;
        end else if (in_byte == CH_SEMI) begin
          act = ACT_DONE;
        end
      end
      default: act = ACT_FAIL;
    endcase
    // A full buffer cannot take another byte.
    if ((act == ACT_BUF) && (pending_count >= CW'(PENDING_DEPTH))) act = ACT_FAIL;
  end

  // Value accumulation: times ten or sixteen, plus the digit.
  always_comb begin
    if (hex_mode) begin
      mul = {1'b0, value_acc, 4'b0};
    end else begin
      mul = {2'b0, value_acc, 3'b0} + {4'b0, value_acc, 1'b0};
    end
    acc_sum = mul + {22'b0, dig_val};
  end

  // UTF-8 encoding of the finished code point.
  always_comb begin
    drop  = value_overflow || (minus_seen && (value_acc != 21'd0));
    utf_b[0] = 8'h00;
    utf_b[1] = 8'h00;
    utf_b[2] = 8'h00;
    utf_b[3] = 8'h00;
    if (drop) begin
      utf_n = 3'd0;
    end else if (value_acc <= 21'h7F) begin
      utf_n    = 3'd1;
      utf_b[0] = value_acc[7:0];
    end else if (value_acc <= 21'h7FF) begin
      utf_n    = 3'd2;
      utf_b[0] = 8'hC0 | {3'b0, value_acc[10:6]};
      utf_b[1] = 8'h80 | {2'b0, value_acc[5:0]};
    end else if (value_acc <= 21'hFFFF) begin
      utf_n    = 3'd3;
      utf_b[0] = 8'hE0 | {4'b0, value_acc[15:12]};
      utf_b[1] = 8'h80 | {2'b0, value_acc[11:6]};
      utf_b[2] = 8'h80 | {2'b0, value_acc[5:0]};
    end else begin
      utf_n    = 3'd4;
      utf_b[0] = 8'hF0 | {5'b0, value_acc[20:18]};
      utf_b[1] = 8'h80 | {2'b0, value_acc[17:12]};
      utf_b[2] = 8'h80 | {2'b0, value_acc[11:6]};
      utf_b[3] = 8'h80 | {2'b0, value_acc[5:0]};
    end
  end

  // Results of this word: held bytes first, then a tail of up to four bytes.
  always_comb begin
    plan_flush  = '0;
    plan_tail_n = 3'd0;
    tail_c      = utf_b;
    if (act == ACT_DONE) begin
      plan_tail_n = utf_n;
    end else if ((act == ACT_FAIL) || final_byte) begin
      plan_flush = pending_count;
      tail_c[0]  = in_byte;
      if (final_byte || (in_byte != CH_AMP)) plan_tail_n = 3'd1;
    end
  end

  assign out_free = !dout.valid || dout.ready;

  always_comb begin
    sts.out_free    = out_free;
    sts.p_has_flush = (plan_flush != '0);
    sts.p_tail_n    = plan_tail_n;
    sts.p_marker    = final_byte && (plan_flush == '0) && (plan_tail_n == 3'd0);
    sts.p_fin       = final_byte;
    sts.q_tail_n    = tail_n_q;
    sts.q_marker    = marker_q;
    sts.q_fin       = fin_q;
  end

  assign flush_cnt = flush_q;

  // Parse state update on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      hex_mode       <= 1'b0;
      minus_seen     <= 1'b0;
      value_acc      <= '0;
      value_overflow <= 1'b0;
      pending_count  <= '0;
    end else if (cmd.accept) begin
      if ((act == ACT_BUF) && !final_byte) begin
        phase         <= nx;
        pending_count <= pending_count + CW'(1);
        if (set_hex) hex_mode <= 1'b1;
        if ((nx == PH_SIGN) && (in_byte == CH_MINUS)) minus_seen <= 1'b1;
        if ((nx == PH_DIGITS) || (nx == PH_ZERO)) begin
          if (value_overflow || (acc_sum > {5'b0, CP_MAX})) begin
            value_overflow <= 1'b1;
          end else begin
            value_acc <= acc_sum[20:0];
          end
        end
      end else begin
        hex_mode       <= 1'b0;
        minus_seen     <= 1'b0;
        value_acc      <= '0;
        value_overflow <= 1'b0;
        if ((act == ACT_FAIL) && !final_byte && (in_byte == CH_AMP)) begin
          phase         <= PH_AMP;
          pending_count <= CW'(1);
        end else begin
          phase         <= PH_IDLE;
          pending_count <= '0;
        end
      end
    end
  end

  // Plan registers for the draining sequence.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flush_q  <= plan_flush;
      tail_n_q <= plan_tail_n;
      tail_q   <= tail_c;
      fin_q    <= final_byte;
      marker_q <= final_byte && (plan_flush == '0) && (plan_tail_n == 3'd0);
    end
  end

  // Pending byte store; a read of entry zero always returns the ampersand.
  always_ff @(posedge clk) begin
    if (cmd.accept && (act == ACT_BUF) && !final_byte) begin
      pending_mem[pending_count[AW-1:0]] <= in_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= (rd_addr == '0) ? CH_AMP : pending_mem[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (cmd.load) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dout.run_last     <= cmd.last;
      dout.text_end     <= cmd.text_end;
      dout.byte_present <= 1'b1;
      case (cmd.sel)
        SEL_DIRECT: dout.out_byte <= tail_c[0];
        SEL_FLUSH:  dout.out_byte <= rd_data;
        SEL_TAIL:   dout.out_byte <= tail_q[cmd.tail_idx];
        default: begin
          dout.out_byte     <= 8'h00;
          dout.byte_present <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/core/nchr_ctrl.sv
`timescale 1ns / 1ps

module nchr_ctrl
  import nchr_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sts_t                               sts,
  input  logic [$clog2(PENDING_DEPTH+1)-1:0] flush_cnt,
  output cmd_t                               cmd,
  output logic [$clog2(PENDING_DEPTH)-1:0]   rd_addr
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = $clog2(PENDING_DEPTH);

  typedef enum logic [2:0] {
    S_ACCEPT,
    S_FL_READ,
    S_FL_SEND,
    S_TAIL,
    S_MARK
  } state_t;

  state_t        state;
  logic [CW-1:0] fidx;
  logic [1:0]    tidx;
  logic [CW-1:0] fidx_inc;
  logic [2:0]    tidx_inc;
  logic          flush_done;
  logic          tail_done;

  assign fidx_inc   = fidx + CW'(1);
  assign tidx_inc   = {1'b0, tidx} + 3'd1;
  assign flush_done = (fidx_inc == flush_cnt);
  assign tail_done  = (tidx_inc == sts.q_tail_n);
  // No word is taken while reset is high.
  assign in_ready   = !rst && (state == S_ACCEPT) && sts.out_free;
  assign rd_addr    = fidx[AW-1:0];

  // Command decode for the current state.
  always_comb begin
    cmd          = '0;
    cmd.sel      = SEL_DIRECT;
    cmd.tail_idx = tidx;
    cmd.accept   = in_valid && in_ready;
    unique case (state)
      S_ACCEPT: begin
        if (cmd.accept && !sts.p_has_flush && (sts.p_tail_n == 3'd1)) begin
          cmd.load     = 1'b1;
          cmd.sel      = SEL_DIRECT;
          cmd.last     = 1'b1;
          cmd.text_end = sts.p_fin;
        end
      end
      S_FL_READ: cmd.rd_en = 1'b1;
      S_FL_SEND: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.sel      = SEL_FLUSH;
          cmd.last     = flush_done && (sts.q_tail_n == 3'd0);
          cmd.text_end = cmd.last && sts.q_fin;
        end
      end
      S_TAIL: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.sel      = SEL_TAIL;
          cmd.last     = tail_done;
          cmd.text_end = tail_done && sts.q_fin;
        end
      end
      S_MARK: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.sel      = SEL_MARK;
          cmd.last     = 1'b1;
          cmd.text_end = 1'b1;
        end
      end
      default: cmd.rd_en = 1'b0;
    endcase
  end

  // Sequencer state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
      fidx  <= '0;
      tidx  <= '0;
    end else begin
      unique case (state)
        S_ACCEPT: begin
          fidx <= '0;
          tidx <= '0;
          if (cmd.accept) begin
            if (sts.p_has_flush) begin
              state <= S_FL_READ;
            end else if (sts.p_tail_n > 3'd1) begin
              state <= S_TAIL;
            end else if (sts.p_marker) begin
              state <= S_MARK;
            end
          end
        end
        S_FL_READ: state <= S_FL_SEND;
        S_FL_SEND: begin
          if (sts.out_free) begin
            fidx <= fidx_inc;
            if (!flush_done) begin
              state <= S_FL_READ;
            end else if (sts.q_tail_n != 3'd0) begin
              state <= S_TAIL;
            end else if (sts.q_marker) begin
              state <= S_MARK;
            end else begin
              state <= S_ACCEPT;
            end
          end
        end
        S_TAIL: begin
          if (sts.out_free) begin
            tidx <= tidx_inc[1:0];
            if (tail_done) state <= S_ACCEPT;
          end
        end
        S_MARK: begin
          if (sts.out_free) state <= S_ACCEPT;
        end
        default: state <= S_ACCEPT;
      endcase
    end
  end

endmodule

### rtl/core/numeric_char_ref_to_utf8.sv
`timescale 1ns / 1ps

// Channel   Role   Word fields
// text      sink   in_byte[7:0], final_byte
// decoded   source out_byte[7:0], byte_present, run_last, text_end
//
// An ordinary byte, or a reference that encodes to one byte, is loaded
// straight into the output register. The UTF-8 bytes of a longer reference
// go out of the output register one word per cycle while it is not stalled.
// Each held byte passed out is first fetched from the pending byte store,
// a registered read. Reset is synchronous; the store is not cleared.
// A stalled output holds its word and the input is not taken meanwhile.

module numeric_char_ref_to_utf8
  import nchr_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  nchr_in_if.sink    text,
  nchr_out_if.source decoded
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = $clog2(PENDING_DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] flush_cnt;
  logic [AW-1:0] rd_addr;
  logic          in_ready;

  assign text.ready = in_ready;

  nchr_ctrl #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text.valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .flush_cnt (flush_cnt),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  nchr_datapath #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (text.in_byte),
    .final_byte (text.final_byte),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .sts        (sts),
    .flush_cnt  (flush_cnt),
    .dout       (decoded)
  );

endmodule

### rtl/core/nchr_checker.sv
`timescale 1ns / 1ps
`include "numeric_char_ref_to_utf8_macros.svh"

module nchr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_present,
  input logic       run_last,
  input logic       text_end
);

  // A stalled output word keeps its contents.
  `NCHR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(text_end))

  // No new text byte is taken while a result waits downstream.
  `NCHR_ASSERT_IMPL(a_no_take_on_stall, clk, rst, out_valid && !out_ready, !in_ready)

  // A word with no byte is only the end-of-text marker.
  `NCHR_ASSERT_IMPL(a_marker_form, clk, rst, out_valid && !byte_present, (out_byte == 8'h00) && run_last && text_end)

  // The end of the text also closes the run of its byte.
  `NCHR_ASSERT_IMPL(a_end_is_last, clk, rst, out_valid && text_end, run_last)

endmodule

bind numeric_char_ref_to_utf8 nchr_checker u_nchr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (text.ready),
  .out_valid    (decoded.valid),
  .out_ready    (decoded.ready),
  .out_byte     (decoded.out_byte),
  .byte_present (decoded.byte_present),
  .run_last     (decoded.run_last),
  .text_end     (decoded.text_end)
);

### tb/sv/tb_numeric_char_ref_to_utf8.sv
`timescale 1ns / 1ps

module tb_numeric_char_ref_to_utf8;
  import nchr_pkg::*;

  localparam int HOLD_DEPTH = PENDING_DEPTH_DEF;
  localparam int RANDOM_BYTES = 450;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int LONG_HOLD = 80;

  // Parse phases of a candidate reference.
  typedef enum logic [3:0] {
    P_IDLE, P_AMP, P_HASH, P_START, P_SPACE, P_SIGN, P_ZERO, P_PREFIX, P_DIGITS
  } ref_phase_t;

  // What a byte does to the reference under way.
  typedef enum logic [1:0] {
    STEP_HOLD, STEP_DONE, STEP_FAIL
  } ref_step_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       text_end;
  } utf8_word_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
    logic       drain;
  } text_word_t;

  logic clk;
  logic rst;

  nchr_in_if  text_ch ();
  nchr_out_if decoded_ch ();

  numeric_char_ref_to_utf8 #(
    .PENDING_DEPTH(HOLD_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .text(text_ch),
    .decoded(decoded_ch)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Decoder state mirrored by the predictor.
  ref_phase_t  phase;
  logic        hex_ref;
  logic        minus_ref;
  logic        ovf_ref;
  logic [20:0] code_acc;
  logic [7:0]  held [HOLD_DEPTH];
  int          held_n;

  utf8_word_t expected_words[$];
  utf8_word_t step_words[$];
  text_word_t text_queue[$];

  int  error_count = 0;
  int  bytes_taken = 0;
  int  total_bytes = 0;
  int  calm_after = 1 << 30;
  int  send_gap = 0;
  int  hold_left = 0;
  int  words_seen = 0;
  int  stall_cycles = 0;
  bit  long_hold_done = 1'b0;
  bit  drain_next = 1'b0;

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ERROR %s: got 0x%02h, expected 0x%02h", $time, field, got, want);
    error_count++;
  endtask

  function automatic bit is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_x_char(input logic [7:0] c);
    return c == "x" || c == "X";
  endfunction

  // Digit value in the current base, or 255 when the byte is not a digit.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex_ref) begin
      if (c >= "a" && c <= "f") return c - "a" + 8'd10;
      if (c >= "A" && c <= "F") return c - "A" + 8'd10;
    end
    return 8'd255;
  endfunction

  function automatic ref_step_t classify_byte(input logic [7:0] c, output ref_phase_t nx);
    ref_phase_t ph;
    logic [7:0] d;
    ph = phase;
    d = digit_value(c);
    nx = P_IDLE;
    if (ph == P_AMP) begin
      if (c == "#") begin
        nx = P_HASH;
        return STEP_HOLD;
      end
      return STEP_FAIL;
    end
    // After the hash, an x selects hex; anything else is parsed as a start byte.
    if (ph == P_HASH) begin
      if (is_x_char(c)) begin
        nx = P_START;
        return STEP_HOLD;
      end
      ph = P_START;
    end
    if (ph == P_START || ph == P_SPACE || ph == P_SIGN) begin
      if (ph == P_START && c == ";") return STEP_DONE;
      if (ph != P_SIGN && is_space(c)) begin
        nx = P_SPACE;
        return STEP_HOLD;
      end
      if (ph != P_SIGN && (c == "+" || c == "-")) begin
        nx = P_SIGN;
        return STEP_HOLD;
      end
      if (hex_ref && c == "0") begin
        nx = P_ZERO;
        return STEP_HOLD;
      end
      if (d != 8'd255) begin
        nx = P_DIGITS;
        return STEP_HOLD;
      end
      return STEP_FAIL;
    end
    if (ph == P_ZERO) begin
      if (is_x_char(c)) begin
        nx = P_PREFIX;
        return STEP_HOLD;
      end
      if (d != 8'd255) begin
        nx = P_DIGITS;
        return STEP_HOLD;
      end
      if (c == ";") return STEP_DONE;
      return STEP_FAIL;
    end
    if (ph == P_PREFIX || ph == P_DIGITS) begin
      if (d != 8'd255) begin
        nx = P_DIGITS;
        return STEP_HOLD;
      end
      if (ph == P_DIGITS && c == ";") return STEP_DONE;
      return STEP_FAIL;
    end
    return STEP_FAIL;
  endfunction

  task automatic clear_ref();
    phase = P_IDLE;
    hex_ref = 1'b0;
    minus_ref = 1'b0;
    ovf_ref = 1'b0;
    code_acc = '0;
    held_n = 0;
  endtask

  task automatic emit_word(input logic [7:0] b, input logic present);
    utf8_word_t w;
    w.out_byte = b;
    w.byte_present = present;
    w.run_last = 1'b0;
    w.text_end = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic flush_held();
    for (int i = 0; i < held_n; i++) emit_word(held[i], 1'b1);
    held_n = 0;
  endtask

  // Once past the code point limit the overflow flag stays set.
  task automatic add_code_digit(input logic [7:0] d);
    logic [31:0] v;
    v = code_acc * (hex_ref ? 32'd16 : 32'd10) + d;
    if (ovf_ref || v > 32'h10FFFF) ovf_ref = 1'b1;
    else code_acc = v[20:0];
  endtask

  // A completed reference becomes one to four UTF-8 bytes, or none if dropped.
  task automatic finish_ref();
    logic [20:0] cp;
    cp = code_acc;
    if (!(ovf_ref || (minus_ref && cp != 21'd0))) begin
      if (cp <= 21'h7F) begin
        emit_word(cp[7:0], 1'b1);
      end else if (cp <= 21'h7FF) begin
        emit_word(8'hC0 | {3'b0, cp[10:6]}, 1'b1);
        emit_word(8'h80 | {2'b0, cp[5:0]}, 1'b1);
      end else if (cp <= 21'hFFFF) begin
        emit_word(8'hE0 | {4'b0, cp[15:12]}, 1'b1);
        emit_word(8'h80 | {2'b0, cp[11:6]}, 1'b1);
        emit_word(8'h80 | {2'b0, cp[5:0]}, 1'b1);
      end else begin
        emit_word(8'hF0 | {5'b0, cp[20:18]}, 1'b1);
        emit_word(8'h80 | {2'b0, cp[17:12]}, 1'b1);
        emit_word(8'h80 | {2'b0, cp[11:6]}, 1'b1);
        emit_word(8'h80 | {2'b0, cp[5:0]}, 1'b1);
      end
    end
    clear_ref();
  endtask

  task automatic idle_byte(input logic [7:0] c);
    if (c == "&") begin
      clear_ref();
      held[0] = c;
      held_n = 1;
      phase = P_AMP;
    end else begin
      emit_word(c, 1'b1);
    end
  endtask

  // Works out the words that one accepted text byte produces.
  task automatic decode_byte(input logic [7:0] c, input logic fin);
    ref_step_t  act;
    ref_phase_t nx;
    utf8_word_t w;
    step_words.delete();
    if (phase == P_IDLE) begin
      idle_byte(c);
    end else begin
      act = classify_byte(c, nx);
      if (act == STEP_HOLD && held_n >= HOLD_DEPTH) act = STEP_FAIL;
      case (act)
        STEP_HOLD: begin
          if (phase == P_HASH && nx == P_START) hex_ref = 1'b1;
          if (nx == P_SIGN && c == "-") minus_ref = 1'b1;
          if (nx == P_DIGITS || nx == P_ZERO) add_code_digit(digit_value(c));
          held[held_n] = c;
          held_n++;
          phase = nx;
        end
        STEP_DONE: begin
          finish_ref();
        end
        default: begin
          flush_held();
          clear_ref();
          idle_byte(c);
        end
      endcase
    end
    if (fin) begin
      flush_held();
      clear_ref();
      if (step_words.size() == 0) emit_word(8'h00, 1'b0);
    end
    for (int i = 0; i < step_words.size(); i++) begin
      w = step_words[i];
      if (i == step_words.size() - 1) begin
        w.run_last = 1'b1;
        w.text_end = fin;
      end
      expected_words.push_back(w);
    end
  endtask

  // Stimulus building.
  task automatic add_byte(input logic [7:0] c);
    text_word_t w;
    w.in_byte = c;
    w.final_byte = 1'b0;
    w.drain = drain_next;
    drain_next = 1'b0;
    text_queue.push_back(w);
  endtask

  task automatic mark_final();
    text_word_t w;
    w = text_queue.pop_back();
    w.final_byte = 1'b1;
    text_queue.push_back(w);
  endtask

  task automatic add_string(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    if (fin) mark_final();
  endtask

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 6);
    return (r == 6) ? 8'h20 : 8'(8'h09 + r);
  endfunction

  function automatic logic [31:0] pick_code_point();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 9))
          0: return 32'h0;
          1: return 32'h7F;
          2: return 32'h80;
          3: return 32'h7FF;
          4: return 32'h800;
          5: return 32'hFFFF;
          6: return 32'h10000;
          7: return 32'h10FFFF;
          8: return 32'h110000;
          default: return 32'h7FFFFFF;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 32'h7F);
      4, 5: return $urandom_range(32'h80, 32'h7FF);
      6: return $urandom_range(32'h800, 32'hFFFF);
      7, 8: return $urandom_range(32'h10000, 32'h10FFFF);
      default: return $urandom_range(32'h110000, 32'h7FFFFFF);
    endcase
  endfunction

  // A well-formed reference with random content, now and then broken.
  task automatic add_reference();
    bit          hexref;
    logic [31:0] value;
    string       digits;
    logic [7:0]  ch;
    int          r;
    hexref = 1'($urandom_range(0, 1));
    add_string("&#", 0);
    if (hexref) add_byte($urandom_range(0, 1) ? "x" : "X");
    if ($urandom_range(0, 5) == 0) begin
      r = $urandom_range(1, 3);
      for (int i = 0; i < r; i++) add_byte(space_char());
    end
    if ($urandom_range(0, 4) == 0) add_byte($urandom_range(0, 1) ? "-" : "+");
    if ($urandom_range(0, 19) != 0) begin
      if (hexref && $urandom_range(0, 3) == 0) begin
        add_byte("0");
        add_byte($urandom_range(0, 1) ? "x" : "X");
      end
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(1, 3);
        for (int i = 0; i < r; i++) add_byte("0");
      end
      value = pick_code_point();
      if (hexref) digits = $sformatf("%0h", value);
      else digits = $sformatf("%0d", value);
      for (int i = 0; i < digits.len(); i++) begin
        ch = digits[i];
        if (ch >= "a" && ch <= "f" && $urandom_range(0, 1)) ch = ch - 8'h20;
        add_byte(ch);
      end
    end
    r = $urandom_range(0, 9);
    if (r == 0) add_byte(8'($urandom_range(0, 255)));
    else if (r != 1) add_byte(";");
  endtask

  // A run whose length lies around the depth of the held-byte store.
  task automatic add_long_run();
    int  n;
    bit  spaces;
    n = $urandom_range(HOLD_DEPTH - 4, HOLD_DEPTH + 4);
    spaces = 1'($urandom_range(0, 1));
    add_string("&#", 0);
    for (int i = 0; i < n; i++) add_byte(spaces ? space_char() : 8'("0"));
    add_byte(";");
  endtask

  task automatic add_noise(input int n);
    logic [7:0] pool [13];
    pool = '{"&", "#", ";", "x", "X", "0", "9", "a", "F", "-", "+", " ", 8'h09};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
      else add_byte(pool[$urandom_range(0, 12)]);
    end
  endtask

  // Reset, stimulus, and the end of the run.
  initial begin
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.in_byte = 8'h00;
    text_ch.final_byte = 1'b0;
    decoded_ch.ready = 1'b0;
    clear_ref();

    // Directed part: empty references, signs, bare prefix, marker-only end.
    add_string("&#;", 0);
    add_string("&#-0;", 0);
    add_string("&#x0x;", 0);
    add_string("&#+;", 0);
    add_string("&#-5;", 1);
    add_byte(8'h00);
    add_byte(8'hFF);
    mark_final();

    // Random part, with the sender draining at the start and near the middle.
    drain_next = 1'b1;
    while (text_queue.size() < RANDOM_BYTES) begin
      if (text_queue.size() >= 250 && text_queue.size() < 260) drain_next = 1'b1;
      case ($urandom_range(0, 15))
        0: add_long_run();
        1, 2, 3: add_noise($urandom_range(1, 4));
        default: add_reference();
      endcase
      if ($urandom_range(0, 9) == 0) mark_final();
    end
    mark_final();
    total_bytes = text_queue.size();
    calm_after = total_bytes - 60;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("numeric_char_ref_to_utf8: match");
    end else begin
      $display("numeric_char_ref_to_utf8: mismatch");
    end
    $finish;
  end

  // Text driver: predicts each accepted word, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (text_ch.valid) begin
        decode_byte(text_ch.in_byte, text_ch.final_byte);
        bytes_taken++;
      end
      if (send_gap > 0) begin
        send_gap--;
        text_ch.valid <= 1'b0;
      end else if (text_queue.size() == 0) begin
        text_ch.valid <= 1'b0;
      end else if (text_queue[0].drain && expected_words.size() != 0) begin
        text_ch.valid <= 1'b0;
      end else if (bytes_taken < calm_after && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 6);
        text_ch.valid <= 1'b0;
      end else begin
        text_ch.valid <= 1'b1;
        text_ch.in_byte <= text_queue[0].in_byte;
        text_ch.final_byte <= text_queue[0].final_byte;
        void'(text_queue.pop_front());
      end
    end
  end

  // Decoded monitor: checks each accepted word and paces ready.
  always @(posedge clk) begin
    utf8_word_t want;
    if (rst) begin
      decoded_ch.ready <= 1'b0;
    end else begin
      if (decoded_ch.valid && decoded_ch.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", decoded_ch.out_byte, 8'h00);
        end else begin
          want = expected_words.pop_front();
          if (decoded_ch.out_byte !== want.out_byte)
            report_mismatch("out_byte", decoded_ch.out_byte, want.out_byte);
          if (decoded_ch.byte_present !== want.byte_present)
            report_mismatch("byte_present", 8'(decoded_ch.byte_present),
                            8'(want.byte_present));
          if (decoded_ch.run_last !== want.run_last)
            report_mismatch("run_last", 8'(decoded_ch.run_last), 8'(want.run_last));
          if (decoded_ch.text_end !== want.text_end)
            report_mismatch("text_end", 8'(decoded_ch.text_end), 8'(want.text_end));
        end
      end
      // One long hold-off lets the block fill and stall its input.
      if (hold_left > 0) begin
        hold_left--;
        decoded_ch.ready <= 1'b0;
      end else if (!long_hold_done && words_seen >= 150) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        decoded_ch.ready <= 1'b0;
      end else if (bytes_taken < calm_after && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 6);
        decoded_ch.ready <= 1'b0;
      end else begin
        decoded_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no word accepted on either side.
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (decoded_ch.valid && decoded_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("numeric_char_ref_to_utf8: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

### numeric_char_ref_to_utf8.f
+incdir+rtl/core
rtl/core/nchr_pkg.sv
rtl/core/nchr_in_if.sv
rtl/core/nchr_out_if.sv
rtl/core/nchr_datapath.sv
rtl/core/nchr_ctrl.sv
rtl/core/numeric_char_ref_to_utf8.sv
rtl/core/nchr_checker.sv
tb/sv/tb_numeric_char_ref_to_utf8.sv
